### src/usb_nrzi_destuff_receiver_top_assert.svh
// ----------------------------------------------------------------------------
// usb nrzi receiver assertion macros
// Concurrent assertion helpers clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef USB_NRZI_DESTUFF_RECEIVER_TOP_ASSERT_SVH
`define USB_NRZI_DESTUFF_RECEIVER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define UNR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define UNR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/unr_pkg.sv
// ----------------------------------------------------------------------------
// unr_pkg
// Shared types, constants and the crc byte update for the usb nrzi receiver.
// ----------------------------------------------------------------------------
package unr_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CRC_W = 16;
  localparam int unsigned RUN_W = 3;
  localparam int unsigned POS_W = 3;

  localparam logic [CRC_W-1:0] CRC_INIT_RST    = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY_RST    = 16'hA001;
  localparam logic [CRC_W-1:0] CRC_RESIDUE_RST = 16'hB001;

  // run count value that means the sync pattern is being hunted
  localparam logic [RUN_W-1:0] HUNT_COUNT  = 3'd7;
  // after this many ones the next bit is a stuffed transition
  localparam logic [RUN_W-1:0] STUFF_COUNT = 3'd6;
  localparam logic [POS_W-1:0] LAST_POS    = 3'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRC_INIT    = 2'd0,
    CFG_CRC_POLY    = 2'd1,
    CFG_CRC_RESIDUE = 2'd2
  } unr_cfg_idx_t;

  typedef struct packed {
    logic line_dplus;
    logic line_dminus;
  } unr_in_t;

  typedef struct packed {
    logic             bit_valid;
    logic             bit_value;
    logic             exit_flag;
    logic             exit_good;
    logic             byte_valid;
    logic [7:0]       byte_data;
    logic [CRC_W-1:0] crc_value;
    logic             crc_good;
  } unr_out_t;

  // decoded line event handed from the line decoder to the byte/crc unit
  typedef struct packed {
    logic emit;
    logic bval;
    logic ex;
    logic good;
  } unr_bit_ev_t;

  function automatic logic [CRC_W-1:0] crc_feed_byte(
    input logic [CRC_W-1:0] crc,
    input logic [7:0]       data,
    input logic [CRC_W-1:0] poly
  );
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ poly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/unr_line_dec.sv
// ----------------------------------------------------------------------------
// unr_line_dec
// Sync hunt, nrzi decode, bit unstuffing and line-state exit detection.
// ----------------------------------------------------------------------------
module unr_line_dec
  import unr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  unr_in_t     sample,
  output unr_bit_ev_t ev
);

  logic             last_level_r, last_level_nxt;
  logic [RUN_W-1:0] run_count_r, run_count_nxt;
  logic             dp, dm;

  assign dp = sample.line_dplus;
  assign dm = sample.line_dminus;

  always_comb begin
    ev             = '0;
    last_level_nxt = last_level_r;
    run_count_nxt  = run_count_r;
    if (!dp && !dm) begin
      // se0: end of packet, good only if a packet was in progress
      ev.ex          = 1'b1;
      ev.good        = (run_count_r != HUNT_COUNT);
      last_level_nxt = 1'b0;
      run_count_nxt  = '0;
    end else if (dp && dm) begin
      ev.ex          = 1'b1;
      last_level_nxt = 1'b0;
      run_count_nxt  = '0;
    end else if (run_count_r == HUNT_COUNT) begin
      // sync ends on two equal low levels; two highs is a bad sync
      if (last_level_r == dp) begin
        if (!dp) begin
          run_count_nxt = '0;
        end else begin
          ev.ex = 1'b1;
        end
      end
      last_level_nxt = dp;
    end else if (dp != last_level_r) begin
      // transition decodes to zero unless it is the stuffed bit
      if (run_count_r != STUFF_COUNT) begin
        ev.emit = 1'b1;
      end
      run_count_nxt  = '0;
      last_level_nxt = dp;
    end else if (run_count_r == STUFF_COUNT) begin
      run_count_nxt = '0;
      ev.ex         = 1'b1;
    end else begin
      ev.emit       = 1'b1;
      ev.bval       = 1'b1;
      run_count_nxt = run_count_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b0;
      run_count_r  <= HUNT_COUNT;
    end else if (advance) begin
      last_level_r <= last_level_nxt;
      run_count_r  <= run_count_nxt;
    end
  end

endmodule

### src/unr_byte_crc.sv
// ----------------------------------------------------------------------------
// unr_byte_crc
// Packs decoded bits lsb first into bytes and runs the reflected crc16.
// ----------------------------------------------------------------------------
module unr_byte_crc
  import unr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  unr_bit_ev_t      ev,
  input  logic [CRC_W-1:0] crc_init,
  input  logic [CRC_W-1:0] crc_poly,
  output logic             byte_valid,
  output logic [7:0]       byte_data,
  output logic [CRC_W-1:0] crc_value
);

  logic [POS_W-1:0] bit_pos_r, bit_pos_nxt;
  logic [7:0]       byte_shift_r, byte_shift_nxt;
  logic             past_first_r, past_first_nxt;
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [7:0]       shift_with;
  logic             byte_done;

  assign shift_with = byte_shift_r | ({7'd0, ev.bval} << bit_pos_r);
  assign byte_done  = ev.emit && (bit_pos_r == LAST_POS);
  assign byte_valid = byte_done;
  assign byte_data  = byte_done ? shift_with : 8'h00;
  // pid byte is skipped by the crc
  assign crc_value  = (byte_done && past_first_r) ?
                      crc_feed_byte(crc_r, shift_with, crc_poly) : crc_r;

  always_comb begin
    bit_pos_nxt    = bit_pos_r;
    byte_shift_nxt = byte_shift_r;
    past_first_nxt = past_first_r;
    crc_nxt        = crc_r;
    if (ev.ex) begin
      bit_pos_nxt    = '0;
      byte_shift_nxt = '0;
      past_first_nxt = 1'b0;
      crc_nxt        = crc_init;
    end else if (ev.emit) begin
      if (byte_done) begin
        bit_pos_nxt    = '0;
        byte_shift_nxt = '0;
        past_first_nxt = 1'b1;
        crc_nxt        = crc_value;
      end else begin
        bit_pos_nxt    = bit_pos_r + 3'd1;
        byte_shift_nxt = shift_with;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_pos_r    <= '0;
      byte_shift_r <= '0;
      past_first_r <= 1'b0;
      crc_r        <= CRC_INIT_RST;
    end else if (advance) begin
      bit_pos_r    <= bit_pos_nxt;
      byte_shift_r <= byte_shift_nxt;
      past_first_r <= past_first_nxt;
      crc_r        <= crc_nxt;
    end
  end

endmodule

### src/usb_nrzi_destuff_receiver_top.sv
// ----------------------------------------------------------------------------
// usb_nrzi_destuff_receiver_top
// Usb low-speed line receiver: nrzi decode, unstuffing, bytes and crc16.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one sampled d+/d- pair per item (in_valid/in_stall/in_data).
//   out channel : exactly one result item per input item, in order
//                 (out_valid/out_stall/out_data).
//   cfg port    : cfg_we/cfg_index/cfg_wdata write crc init, polynomial and
//                 residue; write only while the block is idle.
// Flow: an accepted item is held in the input register, then processed into
//   the output register when it advances, and is taken from there.
// Throughput: one item per cycle while the output is not stalled; the line
//   decoder and byte/crc unit update their state in a single pass, the crc byte step being the longest path.
// Reset: line decoder hunts for sync, byte and crc state are cleared, crc is
//   loaded with 0xffff, config registers take their defaults, both item
//   registers are empty.
// Stall: a stalled result holds; the input register still takes one more
//   item, then in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
`include "usb_nrzi_destuff_receiver_top_assert.svh"

module usb_nrzi_destuff_receiver_top
  import unr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  unr_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output unr_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CRC_W-1:0] crc_init_r, crc_poly_r, crc_residue_r;
  logic             in_valid_r, in_valid_nxt;
  unr_in_t          in_data_r;
  logic             out_valid_r, out_valid_nxt;
  unr_out_t         out_data_r, out_data_nxt;
  logic             advance;
  logic             in_accept;
  unr_bit_ev_t      ev;
  logic             byte_valid;
  logic [7:0]       byte_data;
  logic [CRC_W-1:0] crc_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_init_r    <= CRC_INIT_RST;
      crc_poly_r    <= CRC_POLY_RST;
      crc_residue_r <= CRC_RESIDUE_RST;
    end else if (cfg_we) begin
      case (unr_cfg_idx_t'(cfg_index))
        CFG_CRC_INIT:    crc_init_r    <= cfg_wdata;
        CFG_CRC_POLY:    crc_poly_r    <= cfg_wdata;
        CFG_CRC_RESIDUE: crc_residue_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // process when an item waits and the result slot is free or being taken
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  unr_line_dec u_line_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .sample  (in_data_r),
    .ev      (ev)
  );

  unr_byte_crc u_byte_crc (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .ev         (ev),
    .crc_init   (crc_init_r),
    .crc_poly   (crc_poly_r),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .crc_value  (crc_value)
  );

  always_comb begin
    out_data_nxt.bit_valid  = ev.emit;
    out_data_nxt.bit_value  = ev.emit && ev.bval;
    out_data_nxt.exit_flag  = ev.ex;
    out_data_nxt.exit_good  = ev.ex && ev.good;
    out_data_nxt.byte_valid = byte_valid;
    out_data_nxt.byte_data  = byte_data;
    out_data_nxt.crc_value  = crc_value;
    out_data_nxt.crc_good   = (crc_value == crc_residue_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `UNR_ASSERT_NEXT(a_adv_fills_out, advance, out_valid_r, "processed item lost")
  `UNR_ASSERT_SAME(a_byte_has_bit, out_valid_r && out_data_r.byte_valid,
                   out_data_r.bit_valid, "byte completed without a bit")
  `UNR_ASSERT_SAME(a_exit_no_bit, out_valid_r && out_data_r.exit_flag,
                   !out_data_r.bit_valid, "bit emitted on exit")
  `UNR_ASSERT_SAME(a_good_needs_exit, out_valid_r && out_data_r.exit_good,
                   out_data_r.exit_flag, "good end without exit")

endmodule
